FILE: src/lsb_first_bit_packer_unit_assert.svh
// assertion macros for the lsb-first bit packer checker
// expects signals named clock and reset in the scope of use
`ifndef LSB_FIRST_BIT_PACKER_UNIT_ASSERT_SVH
`define LSB_FIRST_BIT_PACKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LBP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/lbp_pkg.sv
// shared types and constants for the lsb-first bit packer
// no dependencies
`default_nettype none

package lbp_pkg;

   // field widths
   localparam int MaxFieldBits = 64;
   localparam int OpW          = 2;
   localparam int CountW       = 7;
   localparam int CapW         = 16;
   localparam int OffsetW      = 3;
   localparam int PendW        = 7;
   localparam int TotalW       = CapW + OffsetW;
   localparam int ByteW        = 8;

   // work register holds a partial byte plus one aligned field
   localparam int WorkBits = MaxFieldBits + ByteW;
   localparam int MaxBytes = WorkBits / ByteW;
   localparam int NbytesW  = $clog2(MaxBytes + 1);

   localparam logic [CapW-1:0] CapReset = 16'd256;

   // write length limits, capped at the largest field
   localparam int Lim16 = (16 < MaxFieldBits) ? 16 : MaxFieldBits;
   localparam int Lim32 = (32 < MaxFieldBits) ? 32 : MaxFieldBits;
   localparam int Lim64 = (64 < MaxFieldBits) ? 64 : MaxFieldBits;

   // opcodes
   localparam logic [OpW-1:0] OpWrite16 = 2'd0;
   localparam logic [OpW-1:0] OpWrite32 = 2'd1;
   localparam logic [OpW-1:0] OpWrite64 = 2'd2;
   localparam logic [OpW-1:0] OpFinish  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT
   } lbp_state_type;

   // control into the byte shifter
   typedef struct packed {
      logic                load;
      logic                step;
      logic [WorkBits-1:0] work;
      logic [NbytesW-1:0]  nbytes;
   } lbp_shift_ctrl_type;

   // status out of the byte shifter
   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             present;
      logic             last;
      logic [PendW-1:0] next_pending;
   } lbp_shift_stat_type;

endpackage

`default_nettype wire

FILE: src/lbp_byte_shifter.sv
// byte-serial shift register: delivers one packed byte per step
// depends on lbp_pkg
`default_nettype none

module lbp_byte_shifter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lbp_pkg::lbp_shift_ctrl_type ctrl,
   output lbp_pkg::lbp_shift_stat_type      stat
);

   logic [lbp_pkg::WorkBits-1:0] work_ff, work_in;
   logic [lbp_pkg::NbytesW-1:0]  left_ff, left_in;
   logic                         have_byte;

   assign have_byte = (left_ff != '0);

   // load a new aligned word or drop the byte just taken
   always_comb begin
      work_in = work_ff;
      left_in = left_ff;
      if (ctrl.load) begin
         work_in = ctrl.work;
         left_in = ctrl.nbytes;
      end else if (ctrl.step && have_byte) begin
         work_in = work_ff >> lbp_pkg::ByteW;
         left_in = left_ff - lbp_pkg::NbytesW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
      work_ff <= work_in;
   end

   // status of the current step
   always_comb begin
      stat.present      = have_byte;
      stat.out_byte     = have_byte ? work_ff[lbp_pkg::ByteW-1:0] : '0;
      stat.last         = (left_ff <= lbp_pkg::NbytesW'(1));
      stat.next_pending = have_byte ? work_ff[lbp_pkg::ByteW +: lbp_pkg::PendW]
                                    : work_ff[lbp_pkg::PendW-1:0];
   end

endmodule

`default_nettype wire

FILE: src/lsb_first_bit_packer_unit.sv
// lsb-first bit packer: packs fields of 0 to 64 bits into a byte stream.
// Request channel (req_*) takes one transaction: an opcode, a value and a
// bit count. Opcodes write up to 16, 32 or 64 bits, or finish the stream.
// Response channel (rsp_*) returns one result per completed byte, or a
// single result with byte_present low when no byte completes; rsp_last
// marks the final result of a transaction. Each result carries accepted,
// stream_ok and bits_total as they stand after the transaction.
// The csr channel writes capacity_bytes and restarts the stream; it is
// taken only while no transaction is in work.
// Timing: a transaction is accepted, evaluated in the next cycle, then its
// results leave the byte shifter one per cycle while rsp_stall is low. A
// transaction has k results (k is 1 to 8 for a write, 1 for a finish),
// moved out by the byte-serial shifter one byte per cycle unless
// rsp_stall pauses it.
// rsp_stall holds the output register and pauses the shifter; req_stall
// stays high until the last result has been loaded into the output register.
// Reset (synchronous) sets capacity to 256, clears the counters and sets the
// stream flag; no results are pending after reset.
// depends on lbp_pkg and lbp_byte_shifter
`default_nettype none

module lsb_first_bit_packer_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [lbp_pkg::OpW-1:0]            req_opcode,
   input  wire logic [lbp_pkg::MaxFieldBits-1:0]   req_data_value,
   input  wire logic [lbp_pkg::CountW-1:0]         req_bit_count,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [lbp_pkg::ByteW-1:0]               rsp_out_byte,
   output logic                                    rsp_byte_present,
   output logic                                    rsp_accepted,
   output logic                                    rsp_stream_ok,
   output logic [lbp_pkg::TotalW-1:0]              rsp_bits_total,
   output logic                                    rsp_last,
   // configuration channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lbp_pkg::CapW-1:0]           csr_capacity_bytes
);

   lbp_pkg::lbp_state_type state_ff, state_in;

   // captured request
   logic [lbp_pkg::OpW-1:0]          op_ff;
   logic [lbp_pkg::MaxFieldBits-1:0] data_ff;
   logic [lbp_pkg::CountW-1:0]       count_ff;

   // stream state
   logic [lbp_pkg::CapW-1:0]    cap_ff, cap_in;
   logic [lbp_pkg::PendW-1:0]   pending_ff, pending_in;
   logic [lbp_pkg::OffsetW-1:0] offset_ff, offset_in;
   logic [lbp_pkg::CapW-1:0]    bytes_done_ff, bytes_done_in;
   logic                        flag_ff, flag_in;
   logic                        accepted_ff, accepted_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lbp_pkg::ByteW-1:0]   rsp_byte_ff;
   logic                        rsp_present_ff;
   logic                        rsp_accepted_ff;
   logic                        rsp_ok_ff;
   logic [lbp_pkg::TotalW-1:0]  rsp_total_ff;
   logic                        rsp_last_ff;

   // handshake and control
   logic req_take, csr_take, eval_en, step_en, out_free;

   // evaluation datapath
   logic [lbp_pkg::TotalW-1:0]       total_now;
   logic [lbp_pkg::TotalW:0]         total_sum;
   logic [lbp_pkg::CountW-1:0]       limit;
   logic                             write_ok;
   logic [lbp_pkg::MaxFieldBits-1:0] field_mask;
   logic [lbp_pkg::WorkBits-1:0]     aligned;
   logic [lbp_pkg::CountW:0]         bits_after;
   logic                             is_finish;

   lbp_pkg::lbp_shift_ctrl_type shift_ctrl;
   lbp_pkg::lbp_shift_stat_type shift_stat;

   lbp_byte_shifter u_shifter (
      .clock (clock),
      .reset (reset),
      .ctrl  (shift_ctrl),
      .stat  (shift_stat)
   );

   assign req_take = req_valid && !req_stall;
   assign csr_take = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lbp_pkg::ST_IDLE: if (req_take) state_in = lbp_pkg::ST_EVAL;
         lbp_pkg::ST_EVAL: state_in = lbp_pkg::ST_EMIT;
         lbp_pkg::ST_EMIT: if (out_free && shift_stat.last) state_in = lbp_pkg::ST_IDLE;
         default:          state_in = lbp_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      csr_ready = 1'b0;
      eval_en   = 1'b0;
      step_en   = 1'b0;
      unique case (state_ff)
         lbp_pkg::ST_IDLE: begin
            csr_ready = 1'b1;
            req_stall = csr_valid;
         end
         lbp_pkg::ST_EVAL: eval_en = 1'b1;
         lbp_pkg::ST_EMIT: step_en = out_free;
         default: ;
      endcase
   end

   // length limit per write opcode
   always_comb begin
      unique case (op_ff)
         lbp_pkg::OpWrite16: limit = lbp_pkg::CountW'(lbp_pkg::Lim16);
         lbp_pkg::OpWrite32: limit = lbp_pkg::CountW'(lbp_pkg::Lim32);
         default:            limit = lbp_pkg::CountW'(lbp_pkg::Lim64);
      endcase
   end

   // write checks: flag, length limit, byte capacity
   assign is_finish = (op_ff == lbp_pkg::OpFinish);
   assign total_now = {bytes_done_ff, offset_ff};
   assign total_sum = {1'b0, total_now} + (lbp_pkg::TotalW + 1)'(count_ff);
   assign write_ok  = flag_ff && (count_ff <= limit) &&
                      (total_sum <= {1'b0, cap_ff, {lbp_pkg::OffsetW{1'b0}}});

   // mask the field and align it behind the partial byte
   always_comb begin
      for (int i = 0; i < lbp_pkg::MaxFieldBits; i++) begin
         field_mask[i] = ((lbp_pkg::CountW + 1)'(i) < {1'b0, count_ff});
      end
      aligned = ({{lbp_pkg::ByteW{1'b0}}, data_ff & field_mask} << offset_ff) |
                lbp_pkg::WorkBits'(pending_ff);
   end

   assign bits_after = (lbp_pkg::CountW + 1)'(offset_ff) + (lbp_pkg::CountW + 1)'(count_ff);

   // shifter load and step
   always_comb begin
      shift_ctrl.load   = eval_en;
      shift_ctrl.step   = step_en;
      shift_ctrl.work   = lbp_pkg::WorkBits'(pending_ff);
      shift_ctrl.nbytes = '0;
      if (is_finish) begin
         shift_ctrl.nbytes = lbp_pkg::NbytesW'(offset_ff != '0);
      end else if (write_ok) begin
         shift_ctrl.work   = aligned;
         shift_ctrl.nbytes = lbp_pkg::NbytesW'(bits_after >> lbp_pkg::OffsetW);
      end
   end

   // stream state update
   always_comb begin
      cap_in        = cap_ff;
      pending_in    = pending_ff;
      offset_in     = offset_ff;
      bytes_done_in = bytes_done_ff;
      flag_in       = flag_ff;
      accepted_in   = accepted_ff;
      if (csr_take) begin
         cap_in        = csr_capacity_bytes;
         pending_in    = '0;
         offset_in     = '0;
         bytes_done_in = '0;
         flag_in       = (csr_capacity_bytes != '0);
      end else if (eval_en) begin
         if (is_finish) begin
            offset_in     = '0;
            bytes_done_in = '0;
            flag_in       = (cap_ff != '0);
            accepted_in   = 1'b1;
         end else begin
            flag_in     = write_ok;
            accepted_in = write_ok;
            if (write_ok) begin
               offset_in     = bits_after[lbp_pkg::OffsetW-1:0];
               bytes_done_in = bytes_done_ff +
                               lbp_pkg::CapW'(bits_after >> lbp_pkg::OffsetW);
            end
         end
      end else if (step_en && shift_stat.last) begin
         // partial byte left over once the last byte is out
         pending_in = shift_stat.next_pending;
      end
   end

   assign rsp_valid_in = step_en ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lbp_pkg::ST_IDLE;
         cap_ff        <= lbp_pkg::CapReset;
         pending_ff    <= '0;
         offset_ff     <= '0;
         bytes_done_ff <= '0;
         flag_ff       <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         pending_ff    <= pending_in;
         offset_ff     <= offset_in;
         bytes_done_ff <= bytes_done_in;
         flag_ff       <= flag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // request capture and output payload
   always_ff @(posedge clock) begin
      accepted_ff <= accepted_in;
      if (req_take) begin
         op_ff    <= req_opcode;
         data_ff  <= req_data_value;
         count_ff <= req_bit_count;
      end
      if (step_en) begin
         rsp_byte_ff     <= shift_stat.out_byte;
         rsp_present_ff  <= shift_stat.present;
         rsp_accepted_ff <= accepted_ff;
         rsp_ok_ff       <= flag_ff;
         rsp_total_ff    <= total_now;
         rsp_last_ff     <= shift_stat.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_byte_present = rsp_present_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_stream_ok    = rsp_ok_ff;
   assign rsp_bits_total   = rsp_total_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

FILE: src/lbp_checker.sv
// port-level checks for the lsb-first bit packer, bound to the top level
// depends on lbp_pkg and lsb_first_bit_packer_unit_assert.svh
`default_nettype none
`include "lsb_first_bit_packer_unit_assert.svh"

module lbp_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [lbp_pkg::ByteW-1:0]        rsp_out_byte,
   input wire logic                             rsp_byte_present,
   input wire logic                             rsp_accepted,
   input wire logic                             rsp_stream_ok,
   input wire logic [lbp_pkg::TotalW-1:0]       rsp_bits_total,
   input wire logic                             rsp_last
);

   // stalled response transaction holds its byte
   `LBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte), "stalled response changed")

   // an empty result carries a zero byte
   `LBP_ASSERT_IMPLY(a_empty_zero, rsp_valid && !rsp_byte_present, rsp_out_byte == '0, "empty result has nonzero byte")

   // an empty result is the only result of its transaction
   `LBP_ASSERT_IMPLY(a_empty_last, rsp_valid && !rsp_byte_present, rsp_last, "empty result not marked last")

   // a rejected write always clears the stream flag
   `LBP_ASSERT_IMPLY(a_reject_flag, rsp_valid && !rsp_accepted, !rsp_stream_ok, "rejected write left flag set")

   // bits written never exceed 524287, the largest value of the 19-bit total
   `LBP_ASSERT_IMPLY(a_total_range, rsp_valid, rsp_bits_total <= lbp_pkg::TotalW'(524287), "bit total out of range")

endmodule

bind lsb_first_bit_packer_unit lbp_checker u_lbp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_byte_present (rsp_byte_present),
   .rsp_accepted     (rsp_accepted),
   .rsp_stream_ok    (rsp_stream_ok),
   .rsp_bits_total   (rsp_bits_total),
   .rsp_last         (rsp_last)
);

`default_nettype wire

FILE: dv/lsb_first_bit_packer_unit_tb.sv
// self-checking testbench for lsb_first_bit_packer_unit: clocked driver and monitor,
// an in-bench bit-level packing predictor and a queue of expected results
// depends on lbp_pkg and the lsb_first_bit_packer_unit rtl
`timescale 1ns / 1ps

module lsb_first_bit_packer_unit_tb;

   // one request transaction
   typedef struct {
      logic [lbp_pkg::OpW-1:0]          opcode;
      logic [lbp_pkg::MaxFieldBits-1:0] data_value;
      logic [lbp_pkg::CountW-1:0]       bit_count;
   } field_request_type;

   // one response transaction
   typedef struct {
      logic [lbp_pkg::ByteW-1:0]  out_byte;
      logic                       byte_present;
      logic                       accepted;
      logic                       stream_ok;
      logic [lbp_pkg::TotalW-1:0] bits_total;
      logic                       last;
   } packed_byte_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // block ports
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [lbp_pkg::OpW-1:0]          req_opcode = '0;
   logic [lbp_pkg::MaxFieldBits-1:0] req_data_value = '0;
   logic [lbp_pkg::CountW-1:0]       req_bit_count = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [lbp_pkg::ByteW-1:0]        rsp_out_byte;
   logic                             rsp_byte_present;
   logic                             rsp_accepted;
   logic                             rsp_stream_ok;
   logic [lbp_pkg::TotalW-1:0]       rsp_bits_total;
   logic                             rsp_last;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [lbp_pkg::CapW-1:0]         csr_capacity_bytes = '0;

   lsb_first_bit_packer_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_data_value     (req_data_value),
      .req_bit_count      (req_bit_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_present   (rsp_byte_present),
      .rsp_accepted       (rsp_accepted),
      .rsp_stream_ok      (rsp_stream_ok),
      .rsp_bits_total     (rsp_bits_total),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity_bytes (csr_capacity_bytes)
   );

   // stimulus and scoreboard storage
   field_request_type pending_fields [$];
   packed_byte_type   expected_bytes [$];
   int                fields_queued  = 0;
   int                fields_sent    = 0;
   int                writes_refused = 0;
   int                bytes_checked  = 0;
   int                mismatch_count = 0;
   bit                random_idle    = 1'b1;

   // predictor state: capacity, partial byte and counters
   logic [lbp_pkg::CapW-1:0]  cap_bytes;
   logic [lbp_pkg::ByteW-1:0] part_byte;
   int                        part_count;
   logic [lbp_pkg::CapW-1:0]  done_count;
   bit                        stream_flag;

   function automatic int stream_bits();
      return int'(done_count) * lbp_pkg::ByteW + part_count;
   endfunction

   function automatic void restart_stream();
      part_byte   = '0;
      part_count  = 0;
      done_count  = '0;
      stream_flag = (cap_bytes != '0);
   endfunction

   // append one field bit by bit and queue the responses it should cause
   function automatic void predict_packing(input field_request_type rq);
      logic [lbp_pkg::ByteW-1:0] done_bytes [$];
      int                        limit;
      bit                        ok;
      int                        nres;
      packed_byte_type           res;
      if (rq.opcode == lbp_pkg::OpFinish) begin
         if (part_count != 0)
            done_bytes.push_back(part_byte);
         restart_stream();
         ok = 1'b1;
      end else begin
         limit = (rq.opcode == lbp_pkg::OpWrite16) ? 16 :
                 ((rq.opcode == lbp_pkg::OpWrite32) ? 32 : 64);
         if (limit > lbp_pkg::MaxFieldBits)
            limit = lbp_pkg::MaxFieldBits;
         ok = stream_flag && (int'(rq.bit_count) <= limit) &&
              (stream_bits() + int'(rq.bit_count) <= int'(cap_bytes) * lbp_pkg::ByteW);
         stream_flag = ok;
         if (!ok)
            writes_refused++;
         else begin
            for (int i = 0; i < int'(rq.bit_count); i++) begin
               part_byte[part_count] = rq.data_value[i];
               part_count++;
               if (part_count == lbp_pkg::ByteW) begin
                  done_bytes.push_back(part_byte);
                  done_count = done_count + lbp_pkg::CapW'(1);
                  part_byte  = '0;
                  part_count = 0;
               end
            end
         end
      end
      nres = (done_bytes.size() > 0) ? done_bytes.size() : 1;
      for (int k = 0; k < nres; k++) begin
         res.out_byte     = (done_bytes.size() > 0) ? done_bytes[k] : '0;
         res.byte_present = (done_bytes.size() > 0);
         res.accepted     = ok;
         res.stream_ok    = stream_flag;
         res.bits_total   = lbp_pkg::TotalW'(stream_bits());
         res.last         = (k == nres - 1);
         expected_bytes.push_back(res);
      end
   endfunction

   // one line per mismatch, capped so a broken build cannot flood the log
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 100)
         $display("%0t mismatch %s: got 0x%0h want 0x%0h (response %0d)",
                  $time, what, got, want, bytes_checked);
      mismatch_count++;
   endtask

   // driver: hold a stalled transaction, otherwise offer the next field or idle
   always @(posedge clock) begin : field_driver
      field_request_type nxt;
      field_request_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            cur.opcode     = req_opcode;
            cur.data_value = req_data_value;
            cur.bit_count  = req_bit_count;
            predict_packing(cur);
            fields_sent++;
         end
         if (pending_fields.size() != 0 &&
             !(random_idle && $urandom_range(0, 99) < 16)) begin
            nxt = pending_fields.pop_front();
            req_valid      <= 1'b1;
            req_opcode     <= nxt.opcode;
            req_data_value <= nxt.data_value;
            req_bit_count  <= nxt.bit_count;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each response with the oldest expectation
   always @(posedge clock) begin : byte_monitor
      packed_byte_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_out_byte), '0);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch("out_byte", 64'(rsp_out_byte), 64'(want.out_byte));
               if (rsp_byte_present !== want.byte_present)
                  report_mismatch("byte_present", 64'(rsp_byte_present),
                                  64'(want.byte_present));
               if (rsp_accepted !== want.accepted)
                  report_mismatch("accepted", 64'(rsp_accepted), 64'(want.accepted));
               if (rsp_stream_ok !== want.stream_ok)
                  report_mismatch("stream_ok", 64'(rsp_stream_ok), 64'(want.stream_ok));
               if (rsp_bits_total !== want.bits_total)
                  report_mismatch("bits_total", 64'(rsp_bits_total), 64'(want.bits_total));
               if (rsp_last !== want.last)
                  report_mismatch("last", 64'(rsp_last), 64'(want.last));
            end
            bytes_checked++;
         end
         rsp_stall <= random_idle && ($urandom_range(0, 99) < 16);
      end
   end

   task automatic queue_field(input logic [lbp_pkg::OpW-1:0] op, input logic [63:0] value,
                              input int count);
      field_request_type rq;
      rq.opcode     = op;
      rq.data_value = value;
      rq.bit_count  = lbp_pkg::CountW'(count);
      pending_fields.push_back(rq);
      fields_queued++;
   endtask

   // mostly legal writes with random content, some finishes, a few over the limit
   task automatic queue_random_fields(input int n);
      logic [lbp_pkg::OpW-1:0] op;
      int                      limit;
      int                      count;
      int                      pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         op   = (pick < 12) ? lbp_pkg::OpFinish : lbp_pkg::OpW'($urandom_range(0, 2));
         limit = (op == lbp_pkg::OpWrite16) ? 16 :
                 ((op == lbp_pkg::OpWrite32) ? 32 : 64);
         if (pick >= 94)
            count = $urandom_range(limit + 1, 127);
         else if (pick >= 85)
            count = limit;
         else
            count = $urandom_range(0, limit);
         queue_field(op, {$urandom, $urandom}, count);
      end
   endtask

   // wait until every queued transaction has been sent and answered
   task automatic wait_drained();
      while (fields_sent != fields_queued || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // capacity write on an idle block; the stream restarts with it
   task automatic write_capacity(input logic [lbp_pkg::CapW-1:0] cap);
      wait_drained();
      @(posedge clock);
      csr_valid          <= 1'b1;
      csr_capacity_bytes <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cap_bytes = cap;
      restart_stream();
   endtask

   // run limit
   initial begin
      #2_000_000;
      $display("lsb_first_bit_packer_unit_tb: errors");
      $finish;
   end

   // phases of stimulus
   initial begin
      cap_bytes = lbp_pkg::CapReset;
      restart_stream();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: lengths at the limits, refusals and finishes
      queue_field(lbp_pkg::OpWrite16, 64'h0, 0);
      queue_field(lbp_pkg::OpWrite16, 64'hffff_ffff_ffff_ffff, 16);
      queue_field(lbp_pkg::OpWrite32, 64'h0123_4567_89ab_cdef, 32);
      queue_field(lbp_pkg::OpWrite64, 64'hffff_ffff_ffff_ffff, 64);
      queue_field(lbp_pkg::OpWrite64, 64'h5, 3);
      queue_field(lbp_pkg::OpWrite64, 64'hdead_beef_cafe_f00d, 64);
      queue_field(lbp_pkg::OpFinish, 64'h0, 0);
      queue_field(lbp_pkg::OpFinish, 64'h0, 0);
      queue_field(lbp_pkg::OpWrite16, 64'h1_ffff, 17);
      queue_field(lbp_pkg::OpWrite64, 64'h0, 0);
      queue_field(lbp_pkg::OpFinish, 64'h0, 0);
      queue_field(lbp_pkg::OpWrite32, 64'h1_ffff_ffff, 33);
      queue_field(lbp_pkg::OpFinish, 64'hffff_ffff_ffff_ffff, 127);
      queue_field(lbp_pkg::OpWrite64, 64'h8000_0000_0000_0001, 65);
      queue_field(lbp_pkg::OpWrite16, 64'h1, 1);
      queue_field(lbp_pkg::OpFinish, 64'h0, 0);
      queue_field(lbp_pkg::OpWrite16, 64'haaaa_aaaa_aaaa_aaaa, 5);
      queue_field(lbp_pkg::OpWrite32, 64'h5555_5555_5555_5555, 7);
      queue_field(lbp_pkg::OpWrite64, 64'hffff_ffff_ffff_ffff, 127);
      queue_field(lbp_pkg::OpFinish, 64'h0, 0);

      // one byte of capacity: exact fit, then overflow
      write_capacity(16'd1);
      queue_field(lbp_pkg::OpWrite16, 64'ha5, 8);
      queue_field(lbp_pkg::OpWrite16, 64'h0, 0);
      queue_field(lbp_pkg::OpWrite16, 64'h1, 1);
      queue_field(lbp_pkg::OpFinish, 64'h0, 0);
      queue_field(lbp_pkg::OpWrite16, 64'h3ff, 9);
      queue_field(lbp_pkg::OpFinish, 64'h0, 0);

      // zero capacity: every write refused, finish still taken
      write_capacity(16'd0);
      queue_field(lbp_pkg::OpWrite16, 64'h0, 0);
      queue_field(lbp_pkg::OpWrite64, 64'hff, 8);
      queue_field(lbp_pkg::OpFinish, 64'h0, 0);

      // largest capacity with no idling on either side, and a full pause midway
      write_capacity(16'hffff);
      random_idle = 1'b0;
      queue_random_fields(60);
      wait_drained();
      queue_random_fields(40);
      wait_drained();
      random_idle = 1'b1;

      write_capacity(lbp_pkg::CapReset);
      queue_random_fields(80);

      // small capacities so the capacity check trips often
      repeat (3) begin
         write_capacity(lbp_pkg::CapW'($urandom_range(2, 24)));
         queue_random_fields(40);
      end

      wait_drained();
      $display("ran %0d field transactions (%0d writes refused), checked %0d responses",
               fields_sent, writes_refused, bytes_checked);
      $display("capacities covered: 0, 1, 256, 65535 and random small sizes");
      if (mismatch_count == 0)
         $display("lsb_first_bit_packer_unit_tb: clean");
      else
         $display("lsb_first_bit_packer_unit_tb: errors");
      $finish;
   end

endmodule
